@@ hdl/rv32i_subset_execute_macros.svh @@
// ----------------------------------------------------------------------------
// rv32i_subset_execute assertion macros
// Shared property wrappers for the execute block checker.
// ----------------------------------------------------------------------------
`ifndef RV32I_SUBSET_EXECUTE_MACROS_SVH
`define RV32I_SUBSET_EXECUTE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while reset is low
`define RV32EX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rv32i_subset_execute: same-cycle check failed");

// next-cycle implication, sampled on i_clk, off while reset is low
`define RV32EX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rv32i_subset_execute: next-cycle check failed");

`endif

@@ hdl/rv32ex_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32ex_pkg
// Widths, types and command codes shared by the execute block and its checker.
// ----------------------------------------------------------------------------
package rv32ex_pkg;

    // field widths
    localparam int CMD_W    = 5;
    localparam int REG_W    = 5;
    localparam int XLEN     = 32;
    localparam int SHAMT_W  = $clog2(XLEN);
    localparam int IMM_W    = 20;
    localparam int IMM_I_W  = 12;
    localparam int NUM_REGS = 1 << REG_W;
    localparam int BYTE_W   = 8;

    // data memory geometry: four byte lanes, one row holds one aligned word
    localparam int MEM_ADDR_BITS = 12;
    localparam int LANES         = XLEN / BYTE_W;
    localparam int LANE_BITS     = $clog2(LANES);
    localparam int ROW_BITS      = MEM_ADDR_BITS - LANE_BITS;
    localparam int ROWS          = 1 << ROW_BITS;

    // items in flight: input stage, memory stage, output register
    localparam int PIPE_DEPTH = 3;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 2);

    typedef logic [CMD_W-1:0]            t_cmd;
    typedef logic [REG_W-1:0]            t_reg;
    typedef logic [XLEN-1:0]             t_word;
    typedef logic signed [XLEN-1:0]      t_sword;
    typedef logic signed [IMM_W-1:0]     t_imm;
    typedef logic [BYTE_W-1:0]           t_byte;
    typedef logic [ROW_BITS-1:0]         t_row;
    typedef logic [LANE_BITS-1:0]        t_lane;
    typedef logic [SHAMT_W-1:0]          t_shamt;
    typedef logic [CNT_W-1:0]            t_cnt;

    // command codes
    localparam t_cmd CMD_ADD  = t_cmd'(0);
    localparam t_cmd CMD_SUB  = t_cmd'(1);
    localparam t_cmd CMD_AND  = t_cmd'(2);
    localparam t_cmd CMD_OR   = t_cmd'(3);
    localparam t_cmd CMD_XOR  = t_cmd'(4);
    localparam t_cmd CMD_SLT  = t_cmd'(5);
    localparam t_cmd CMD_SLL  = t_cmd'(6);
    localparam t_cmd CMD_SRA  = t_cmd'(7);
    localparam t_cmd CMD_ADDI = t_cmd'(8);
    localparam t_cmd CMD_ANDI = t_cmd'(9);
    localparam t_cmd CMD_ORI  = t_cmd'(10);
    localparam t_cmd CMD_XORI = t_cmd'(11);
    localparam t_cmd CMD_SLTI = t_cmd'(12);
    localparam t_cmd CMD_LUI  = t_cmd'(13);
    localparam t_cmd CMD_LW   = t_cmd'(14);
    localparam t_cmd CMD_LB   = t_cmd'(15);
    localparam t_cmd CMD_SW   = t_cmd'(16);
    localparam t_cmd CMD_SB   = t_cmd'(17);

endpackage

@@ hdl/rv32i_subset_execute.sv @@
// ----------------------------------------------------------------------------
// rv32i_subset_execute
// Executes one decoded RV32I-subset instruction per beat against a 32-entry
// register file and a little-endian byte memory, and reports the register
// write it causes. One instruction is taken per cycle while o_stall is low.
// Each result passes the input register (with register read) and the
// execute stage (with memory access) and is presented from the output
// register. Results of earlier instructions, loads included, are
// forwarded, so back-to-back dependent instructions never wait. The memory
// is four byte lanes of 2^(MEM_ADDR_BITS-2) rows, which lets an unaligned
// word access be done as a single access to all four lanes. After reset
// the block zeroes the memory one row per cycle, all 2^(MEM_ADDR_BITS-2) =
// 1024 rows, and holds o_stall high until that is done.
// ----------------------------------------------------------------------------
module rv32i_subset_execute (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // instruction channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rv32ex_pkg::t_cmd     i_command,
    input  rv32ex_pkg::t_reg     i_dest_reg,
    input  rv32ex_pkg::t_reg     i_src_reg_a,
    input  rv32ex_pkg::t_reg     i_src_reg_b,
    input  rv32ex_pkg::t_imm     i_immediate,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_reg_written,
    output rv32ex_pkg::t_reg     o_written_reg,
    output rv32ex_pkg::t_sword   o_written_value
);
    import rv32ex_pkg::*;

    // pipeline control
    logic   in_acc;
    logic   a_adv;
    logic   a_free;
    logic   b_adv;
    logic   b_free;

    // memory clearing pass
    logic   r_clr_busy;
    t_row   r_clr_row;

    // register file
    t_word              r_rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;
    logic               rf_we;
    t_reg               rf_wa;
    t_word              rf_wd;

    // execute stage (a)
    logic   r_a_valid;
    t_cmd   r_a_cmd;
    t_reg   r_a_rd;
    t_reg   r_a_rs1;
    t_reg   r_a_rs2;
    t_imm   r_a_imm;
    t_word  r_a_op1;
    t_word  r_a_op2;
    t_word  op_a;
    t_word  op_b;
    t_word  imm_i;
    t_word  alu;
    t_word  eff_addr;
    t_shamt shamt;
    t_lane  a_off;
    t_row   a_row;
    logic   a_wr;
    logic   a_ld;

    // byte lanes
    t_row   bank_row [LANES];
    t_byte  bank_wd  [LANES];
    t_lane  lane_sel [LANES];
    logic   bank_we  [LANES];
    logic   bank_re;
    t_byte  r_bank_q [LANES];

    // memory stage (b)
    logic   r_b_valid;
    logic   r_b_wr;
    t_reg   r_b_rd;
    t_word  r_b_alu;
    logic   r_b_lw;
    logic   r_b_lb;
    t_lane  r_b_off;
    t_byte  ld_byte [LANES];
    t_word  ld_word;
    t_word  ld_sbyte;
    t_word  b_value;

    // output register
    logic   r_o_valid;
    logic   r_o_wr;
    t_reg   r_o_reg;
    t_word  r_o_val;

    // handshake: each stage moves on once the one after it has room
    assign b_adv  = r_b_valid && (!r_o_valid || !i_stall);
    assign b_free = !r_b_valid || b_adv;
    assign a_adv  = r_a_valid && b_free;
    assign a_free = !r_a_valid || a_adv;
    assign o_stall = r_clr_busy || !a_free;
    assign in_acc  = i_valid && !o_stall;

    // memory clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            r_clr_row <= r_clr_row + t_row'(1);
            if (&r_clr_row) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // register file write port, fed by the memory stage
    assign rf_we = b_adv && r_b_wr;
    assign rf_wa = r_b_rd;
    assign rf_wd = b_value;

    // entries never written read as zero, x0 is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[rf_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
    end

    // input beat: capture fields and read both sources, bypassing this cycle's write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cmd <= i_command;
            r_a_rd  <= i_dest_reg;
            r_a_rs1 <= i_src_reg_a;
            r_a_rs2 <= i_src_reg_b;
            r_a_imm <= i_immediate;
            if (rf_we && rf_wa == i_src_reg_a) begin
                r_a_op1 <= rf_wd;
            end else if (r_rf_vld[i_src_reg_a]) begin
                r_a_op1 <= r_rf[i_src_reg_a];
            end else begin
                r_a_op1 <= '0;
            end
            if (rf_we && rf_wa == i_src_reg_b) begin
                r_a_op2 <= rf_wd;
            end else if (r_rf_vld[i_src_reg_b]) begin
                r_a_op2 <= r_rf[i_src_reg_b];
            end else begin
                r_a_op2 <= '0;
            end
        end
    end

    // operand forwarding from the instruction one stage ahead
    always_comb begin
        op_a = r_a_op1;
        op_b = r_a_op2;
        if (r_b_valid && r_b_wr && r_b_rd == r_a_rs1) begin
            op_a = b_value;
        end
        if (r_b_valid && r_b_wr && r_b_rd == r_a_rs2) begin
            op_b = b_value;
        end
    end

    // immediate, effective address and shift amount
    assign imm_i    = {{(XLEN-IMM_I_W){r_a_imm[IMM_I_W-1]}}, r_a_imm[IMM_I_W-1:0]};
    assign eff_addr = op_a + imm_i;
    assign shamt    = op_b[SHAMT_W-1:0];
    assign a_off    = eff_addr[LANE_BITS-1:0];
    assign a_row    = eff_addr[MEM_ADDR_BITS-1:LANE_BITS];
    assign a_ld     = r_a_cmd inside {CMD_LW, CMD_LB};

    // alu
    always_comb begin
        a_wr = 1'b1;
        alu  = '0;
        case (r_a_cmd)
            CMD_ADD:  alu = op_a + op_b;
            CMD_SUB:  alu = op_a - op_b;
            CMD_AND:  alu = op_a & op_b;
            CMD_OR:   alu = op_a | op_b;
            CMD_XOR:  alu = op_a ^ op_b;
            CMD_SLT:  alu = t_word'($signed(op_a) < $signed(op_b));
            CMD_SLL:  alu = op_a << shamt;
            CMD_SRA:  alu = t_word'($signed(op_a) >>> shamt);
            CMD_ADDI: alu = eff_addr;
            CMD_ANDI: alu = op_a & imm_i;
            CMD_ORI:  alu = op_a | imm_i;
            CMD_XORI: alu = op_a ^ imm_i;
            CMD_SLTI: alu = t_word'($signed(op_a) < $signed(imm_i));
            CMD_LUI:  alu = {r_a_imm, {(XLEN-IMM_W){1'b0}}};
            CMD_LW:   alu = '0;
            CMD_LB:   alu = '0;
            default:  a_wr = 1'b0;
        endcase
    end

    // lane addressing: lanes below the start offset take the next row
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lane_sel[k] = t_lane'(k) - a_off;
            bank_row[k] = a_row + t_row'(t_lane'(k) < a_off);
            bank_wd[k]  = t_byte'(op_b >> {lane_sel[k], {$clog2(BYTE_W){1'b0}}});
            bank_we[k]  = a_adv && (r_a_cmd == CMD_SW ||
                                    (r_a_cmd == CMD_SB && t_lane'(k) == a_off));
        end
    end

    assign bank_re = a_adv && a_ld;

    // byte lanes, zeroed row by row after reset
    for (genvar k = 0; k < LANES; k++) begin : g_bank
        t_byte r_mem [ROWS];

        always_ff @(posedge i_clk) begin
            if (r_clr_busy) begin
                r_mem[r_clr_row] <= '0;
            end else if (bank_we[k]) begin
                r_mem[bank_row[k]] <= bank_wd[k];
            end
            if (bank_re) begin
                r_bank_q[k] <= r_mem[bank_row[k]];
            end
        end
    end

    // memory stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_wr  <= a_wr && r_a_rd != '0;
            r_b_rd  <= r_a_rd;
            r_b_alu <= alu;
            r_b_lw  <= r_a_cmd == CMD_LW;
            r_b_lb  <= r_a_cmd == CMD_LB;
            r_b_off <= a_off;
        end
    end

    // load data: rotate lanes back into byte order
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            ld_byte[i] = r_bank_q[r_b_off + t_lane'(i)];
            ld_word[i*BYTE_W +: BYTE_W] = ld_byte[i];
        end
    end

    assign ld_sbyte = {{(XLEN-BYTE_W){ld_byte[0][BYTE_W-1]}}, ld_byte[0]};
    assign b_value  = r_b_lw ? ld_word : (r_b_lb ? ld_sbyte : r_b_alu);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_o_wr  <= r_b_wr;
            r_o_reg <= r_b_wr ? r_b_rd : '0;
            r_o_val <= r_b_wr ? b_value : '0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_reg_written   = r_o_wr;
    assign o_written_reg   = r_o_reg;
    assign o_written_value = $signed(r_o_val);

endmodule

@@ hdl/rv32ex_chk.sv @@
// ----------------------------------------------------------------------------
// rv32ex_chk
// Port-level checks for the execute block, attached by bind.
// ----------------------------------------------------------------------------
`include "rv32i_subset_execute_macros.svh"

module rv32ex_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  rv32ex_pkg::t_cmd     i_command,
    input  rv32ex_pkg::t_reg     i_dest_reg,
    input  rv32ex_pkg::t_reg     i_src_reg_a,
    input  rv32ex_pkg::t_reg     i_src_reg_b,
    input  rv32ex_pkg::t_imm     i_immediate,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic                 o_reg_written,
    input  rv32ex_pkg::t_reg     o_written_reg,
    input  rv32ex_pkg::t_sword   o_written_value
);
    import rv32ex_pkg::*;

    logic   in_beat;
    logic   out_beat;
    t_cnt   r_cnt;
    t_cnt   n_cnt;

    // instructions accepted but not yet delivered
    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;
    assign n_cnt    = r_cnt + t_cnt'(in_beat) - t_cnt'(out_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a stalled result holds
    `RV32EX_ASSERT_NXT(ap_out_hold, o_valid && i_stall, o_valid && $stable(o_reg_written) && $stable(o_written_reg) && $stable(o_written_value))

    // no write reported means an all-zero result
    `RV32EX_ASSERT_IMP(ap_no_write_zero, o_valid && !o_reg_written, o_written_reg == '0 && o_written_value == '0)

    // x0 is never reported as written
    `RV32EX_ASSERT_IMP(ap_write_nonzero, o_valid && o_reg_written, o_written_reg != '0)

    // every result belongs to an accepted instruction
    `RV32EX_ASSERT_IMP(ap_no_orphan, o_valid, r_cnt != '0)

    // never more in flight than the pipeline holds
    `RV32EX_ASSERT_IMP(ap_depth, in_beat || !in_beat, r_cnt <= t_cnt'(PIPE_DEPTH))

    // inputs seen only for binding
    logic unused_inputs;
    assign unused_inputs = ^{i_command, i_dest_reg, i_src_reg_a, i_src_reg_b, i_immediate};

endmodule

bind rv32i_subset_execute rv32ex_chk u_rv32ex_chk (.*);

@@ tb/rv32i_subset_execute_checker.sv @@
// ----------------------------------------------------------------------------
// rv32i_subset_execute_checker
// Watches the instruction and result channels of the execute block. Keeps
// its own register file and byte memory, works out the register write each
// accepted instruction beat should report, and compares every result beat
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // instruction channel as seen at the block
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  rv32ex_pkg::t_cmd     i_command,
    input  rv32ex_pkg::t_reg     i_dest_reg,
    input  rv32ex_pkg::t_reg     i_src_reg_a,
    input  rv32ex_pkg::t_reg     i_src_reg_b,
    input  rv32ex_pkg::t_imm     i_immediate,
    // result channel as seen at the block
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_reg_written,
    input  rv32ex_pkg::t_reg     i_written_reg,
    input  rv32ex_pkg::t_sword   i_written_value,
    // status for the top
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_reg_writes
);
    import rv32ex_pkg::*;

    localparam int MEM_BYTES   = 1 << MEM_ADDR_BITS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic  written;
        t_reg  rg;
        t_word value;
    } t_reg_write;

    // shadow architectural state
    t_word      shadow_regs [NUM_REGS];
    t_byte      shadow_mem  [MEM_BYTES];
    t_reg_write predicted_writes [$];

    // execute one instruction on the shadow state, return its register write
    function automatic t_reg_write execute_instr(input t_cmd cmd, input t_reg rd,
                                                 input t_reg ra, input t_reg rb,
                                                 input t_imm imm);
        t_word                    a;
        t_word                    b;
        t_word                    simm;
        t_word                    addr;
        t_word                    addr_k;
        t_word                    val;
        logic [MEM_ADDR_BITS-1:0] byte_addr;
        logic                     writes;
        t_reg_write               res;
        a      = shadow_regs[ra];
        b      = shadow_regs[rb];
        simm   = {{(XLEN-IMM_I_W){imm[IMM_I_W-1]}}, imm[IMM_I_W-1:0]};
        addr   = a + simm;
        val    = '0;
        writes = 1'b1;
        case (cmd)
            CMD_ADD:  val = a + b;
            CMD_SUB:  val = a - b;
            CMD_AND:  val = a & b;
            CMD_OR:   val = a | b;
            CMD_XOR:  val = a ^ b;
            CMD_SLT:  val = ($signed(a) < $signed(b)) ? t_word'(1) : t_word'(0);
            CMD_SLL:  val = a << b[SHAMT_W-1:0];
            CMD_SRA:  val = $signed(a) >>> b[SHAMT_W-1:0];
            CMD_ADDI: val = a + simm;
            CMD_ANDI: val = a & simm;
            CMD_ORI:  val = a | simm;
            CMD_XORI: val = a ^ simm;
            CMD_SLTI: val = ($signed(a) < $signed(simm)) ? t_word'(1) : t_word'(0);
            CMD_LUI:  val = {imm, {IMM_I_W{1'b0}}};
            // little-endian word, each byte address wraps on its own
            CMD_LW: begin
                for (int k = 0; k < LANES; k++) begin
                    addr_k    = addr + t_word'(k);
                    byte_addr = addr_k[MEM_ADDR_BITS-1:0];
                    val[BYTE_W*k +: BYTE_W] = shadow_mem[byte_addr];
                end
            end
            CMD_LB: begin
                byte_addr = addr[MEM_ADDR_BITS-1:0];
                val = {{(XLEN-BYTE_W){shadow_mem[byte_addr][BYTE_W-1]}},
                       shadow_mem[byte_addr]};
            end
            CMD_SW: begin
                for (int k = 0; k < LANES; k++) begin
                    addr_k    = addr + t_word'(k);
                    byte_addr = addr_k[MEM_ADDR_BITS-1:0];
                    shadow_mem[byte_addr] = b[BYTE_W*k +: BYTE_W];
                end
                writes = 1'b0;
            end
            CMD_SB: begin
                byte_addr = addr[MEM_ADDR_BITS-1:0];
                shadow_mem[byte_addr] = b[BYTE_W-1:0];
                writes = 1'b0;
            end
            default: writes = 1'b0;
        endcase
        // x0 stays zero, nothing reported for it
        if (writes && rd != '0) begin
            shadow_regs[rd] = val;
            res = '{written: 1'b1, rg: rd, value: val};
        end else begin
            res = '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_reg_write want,
                                   input t_reg_write got);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTS)
            $display({"checker: %s: expected written=%0b reg=%0d value=%h,",
                      " got written=%0b reg=%0d value=%h"},
                     what, want.written, want.rg, want.value,
                     got.written, got.rg, got.value);
    endtask

    // result beats are checked before the instruction beat of the same edge
    always @(posedge i_clk) begin : watch
        t_reg_write got;
        t_reg_write want;
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) shadow_regs[r] = '0;
            for (int m = 0; m < MEM_BYTES; m++) shadow_mem[m] = '0;
            predicted_writes.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_reg_writes = 0;
            o_pending    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{written: i_reg_written, rg: i_written_reg,
                        value: t_word'(i_written_value)};
                if (predicted_writes.size() == 0) begin
                    report_mismatch("result with nothing outstanding", '0, got);
                end else begin
                    want = predicted_writes.pop_front();
                    o_checked++;
                    if (got.written)
                        o_reg_writes++;
                    if (got.written !== want.written || got.rg !== want.rg ||
                        got.value !== want.value)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (i_in_valid && !i_in_stall)
                predicted_writes.push_back(execute_instr(i_command, i_dest_reg,
                                                         i_src_reg_a, i_src_reg_b,
                                                         i_immediate));
            o_pending = predicted_writes.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives decoded instructions into the execute block: a directed opening
// over operand extremes, every command, x0 handling, unknown commands,
// wrapping and unaligned memory access, then a long random mix with random
// gaps and result stalls and one long result hold-off. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import rv32ex_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int NUM_RANDOM   = 600;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT      = 2_000_000;

    // commands the block does not implement
    localparam t_cmd CMD_NONE_LO = t_cmd'(18);
    localparam t_cmd CMD_NONE_HI = t_cmd'(31);

    logic   i_clk           = 1'b0;
    logic   i_rst_n         = 1'b0;
    logic   i_valid         = 1'b0;
    logic   o_stall;
    t_cmd   i_command       = CMD_ADD;
    t_reg   i_dest_reg      = '0;
    t_reg   i_src_reg_a     = '0;
    t_reg   i_src_reg_b     = '0;
    t_imm   i_immediate     = '0;
    logic   o_valid;
    logic   i_stall         = 1'b0;
    logic   o_reg_written;
    t_reg   o_written_reg;
    t_sword o_written_value;

    int     mismatches;
    int     pending;
    int     checked;
    int     reg_writes;
    int     issued          = 0;
    int     directed        = 0;
    int     sink_beats      = 0;
    int     sink_wait       = 0;
    logic   hold_request    = 1'b0;
    logic   long_hold       = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    rv32i_subset_execute i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_dest_reg      (i_dest_reg),
        .i_src_reg_a     (i_src_reg_a),
        .i_src_reg_b     (i_src_reg_b),
        .i_immediate     (i_immediate),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reg_written   (o_reg_written),
        .o_written_reg   (o_written_reg),
        .o_written_value (o_written_value)
    );

    rv32i_subset_execute_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_command       (i_command),
        .i_dest_reg      (i_dest_reg),
        .i_src_reg_a     (i_src_reg_a),
        .i_src_reg_b     (i_src_reg_b),
        .i_immediate     (i_immediate),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_reg_written   (o_reg_written),
        .i_written_reg   (o_written_reg),
        .i_written_value (o_written_value),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_reg_writes    (reg_writes)
    );

    // result side: random stall after each beat, calm stretches, long hold
    always @(posedge i_clk) begin : result_sink
        int n;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            sink_wait <= 0;
        end else if (long_hold) begin
            i_stall <= 1'b1;
        end else if (sink_wait != 0) begin
            i_stall   <= 1'b1;
            sink_wait <= sink_wait - 1;
        end else if (o_valid && !i_stall) begin
            sink_beats <= sink_beats + 1;
            n = (sink_beats % 128 >= 96) ? 0 : $urandom_range(0, 7);
            i_stall   <= (n != 0);
            sink_wait <= (n != 0) ? n - 1 : 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // long hold-off on the result side, counted here while input keeps coming
    initial begin : result_hold
        wait (hold_request);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin : watchdog
        #TIMEOUT;
        $display("testbench: FAIL");
        $finish;
    end

    // present one instruction beat after a random gap, wait until taken
    task automatic issue(input t_cmd cmd, input t_reg rd, input t_reg ra,
                         input t_reg rb, input t_imm imm);
        int gap;
        gap = (issued % 128 >= 96) ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_dest_reg  <= rd;
        i_src_reg_a <= ra;
        i_src_reg_b <= rb;
        i_immediate <= imm;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        issued++;
    endtask

    // registers mostly from a small set so results feed each other
    function automatic t_reg random_reg();
        return ($urandom_range(0, 3) == 0) ? t_reg'($urandom_range(0, 31))
                                           : t_reg'($urandom_range(0, 7));
    endfunction

    initial begin : stimulus
        t_cmd cmd;
        t_reg ra;
        t_imm imm;
        int   r;
        int   offs;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // operand extremes and every command
        issue(CMD_LUI,  5'd1,  5'd0,  5'd0,  -524288);
        issue(CMD_LUI,  5'd3,  5'd0,  5'd0,  524287);
        issue(CMD_ADDI, 5'd2,  5'd0,  5'd0,  524287);
        issue(CMD_ADDI, 5'd4,  5'd0,  5'd0,  2047);
        issue(CMD_ADDI, 5'd10, 5'd0,  5'd0,  35);
        issue(CMD_ADD,  5'd5,  5'd1,  5'd2,  0);
        issue(CMD_SUB,  5'd6,  5'd1,  5'd4,  0);
        issue(CMD_AND,  5'd7,  5'd3,  5'd2,  0);
        issue(CMD_OR,   5'd8,  5'd1,  5'd4,  0);
        issue(CMD_XOR,  5'd9,  5'd5,  5'd2,  0);
        // signed compares across the sign boundary
        issue(CMD_SLT,  5'd11, 5'd1,  5'd4,  0);
        issue(CMD_SLT,  5'd12, 5'd4,  5'd1,  0);
        issue(CMD_SLTI, 5'd18, 5'd1,  5'd0,  0);
        issue(CMD_SLTI, 5'd19, 5'd4,  5'd0,  -1);
        // shift amounts taken from the low five bits only
        issue(CMD_SLL,  5'd13, 5'd4,  5'd10, 0);
        issue(CMD_SRA,  5'd14, 5'd1,  5'd10, 0);
        issue(CMD_SLL,  5'd24, 5'd4,  5'd2,  0);
        issue(CMD_ANDI, 5'd15, 5'd2,  5'd0,  -2048);
        issue(CMD_ORI,  5'd16, 5'd0,  5'd0,  -1);
        issue(CMD_XORI, 5'd17, 5'd5,  5'd0,  -1);
        // word store wrapping off the top of memory, then a store of x0
        issue(CMD_SW,   5'd31, 5'd0,  5'd2,  -1);
        issue(CMD_SB,   5'd0,  5'd0,  5'd0,  0);
        issue(CMD_LW,   5'd20, 5'd0,  5'd0,  -1);
        issue(CMD_LB,   5'd21, 5'd0,  5'd0,  -1);
        issue(CMD_LW,   5'd23, 5'd1,  5'd0,  2047);
        // write to x0 is dropped, unknown command does nothing
        issue(CMD_ADD,  5'd0,  5'd1,  5'd2,  0);
        issue(CMD_NONE_HI, 5'd31, 5'd31, 5'd31, -1);
        directed = issued;

        // random mix, half the memory traffic in a small window near zero
        for (int i = 0; i < NUM_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                cmd = t_cmd'($urandom_range(CMD_NONE_LO, CMD_NONE_HI));
            else if (r < 35)
                cmd = t_cmd'($urandom_range(CMD_LW, CMD_SB));
            else
                cmd = t_cmd'($urandom_range(CMD_ADD, CMD_LUI));
            imm = t_imm'($urandom);
            ra  = random_reg();
            if (cmd >= CMD_LW && cmd <= CMD_SB && $urandom_range(0, 1) == 1) begin
                ra   = '0;
                offs = $urandom_range(0, 63) - 32;
                imm[IMM_I_W-1:0] = offs[IMM_I_W-1:0];
            end
            if (i == NUM_RANDOM / 2)
                hold_request <= 1'b1;
            issue(cmd, random_reg(), ra, random_reg(), imm);
        end
        i_valid <= 1'b0;

        // let the last beat land in the checker, then drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("testbench: %0d instructions issued (%0d directed), %0d results checked, %0d register writes",
                 issued, directed, checked, reg_writes);
        $display("testbench: results held off once for %0d cycles with input still offered",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
